FILE: sv/rqs_pkg.sv
package rqs_pkg;

  localparam int unsigned QueueDepth = 32;
  localparam int unsigned IdxW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  // policy codes
  localparam logic [2:0] MODE_FCFS = 3'd0;
  localparam logic [2:0] MODE_LCFS = 3'd1;
  localparam logic [2:0] MODE_SJF  = 3'd2;
  localparam logic [2:0] MODE_RR   = 3'd3;
  localparam logic [2:0] MODE_PRIO = 3'd4;

  // request codes
  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_EXP = 2'd1;
  localparam logic [1:0] FUNC_GET = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // register index
  localparam logic [0:0] REG_POLICY_MODE = 1'b0;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  pid;
    logic [15:0] burst_key;
    logic [1:0]  level;
  } req_t;

  typedef struct packed {
    logic [7:0] pid_out;
    logic       grant_valid;
    logic [1:0] status;
    logic       queue_empty;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  pid;
    logic [15:0] key;
    logic [1:0]  level;
    logic        bank;
  } slot_t;

  localparam int unsigned SlotW = $bits(slot_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RDREQ,
    ST_RDCAP,
    ST_SHUP,
    ST_SHDN,
    ST_WRNEW,
    ST_DONE
  } eng_state_e;

endpackage

FILE: sv/rqs_ram.sv
module rqs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/rqs_engine.sv
module rqs_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  rqs_pkg::req_t req_i,
  input  logic [2:0]    mode_i,
  output logic          busy_o,
  output logic          res_valid_o,
  input  logic          res_take_i,
  output rqs_pkg::rsp_t res_o
);
  import rqs_pkg::*;

  eng_state_e state_q, state_d;
  req_t        req_q, req_d;
  logic [2:0]  mode_q, mode_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic        ab_q, ab_d;
  logic [IdxW-1:0] pos_q, pos_d, idx_q, idx_d, pidx_q, pidx_d;
  logic        act_q, act_d, pend_q, pend_d;
  logic [7:0]  pid_q, pid_d;
  logic        grant_q, grant_d;
  logic [1:0]  status_q, status_d;
  logic [1:0]  bf_q, bf_d;
  logic [1:0]  bl_q [2];
  logic [1:0]  bl_d [2];
  logic [IdxW-1:0] bp_q [2];
  logic [IdxW-1:0] bp_d [2];
  logic [7:0]  bpid_q [2];
  logic [7:0]  bpid_d [2];

  logic        ram_we, ram_re;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  slot_t       ram_wdata, rd;
  logic [SlotW-1:0] rd_raw;

  logic [2:0]  eff_mode;
  logic        is_add, is_get, full;
  logic [IdxW-1:0] cnt_last;
  logic        sjf_hit, scan_last, shift_done;
  slot_t       new_slot;
  logic        sel;

  rqs_ram #(
    .Width (SlotW),
    .Depth (QueueDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_raw)
  );

  assign rd = slot_t'(rd_raw);

  // request decode at accept time
  assign eff_mode = (mode_i > MODE_PRIO) ? MODE_FCFS : mode_i;
  assign is_add   = (req_i.func == FUNC_ADD) ||
                    ((req_i.func == FUNC_EXP) && (eff_mode == MODE_PRIO));
  assign is_get   = (req_i.func == FUNC_GET);
  assign full     = (cnt_q == CntW'(QueueDepth));
  assign cnt_last = IdxW'(cnt_q - 1'b1);

  // walk status
  assign sjf_hit    = pend_q && (mode_q == MODE_SJF) && (req_q.burst_key < rd.key);
  assign scan_last  = pend_q && (pidx_q == cnt_last);
  assign shift_done = !act_q && !pend_q;

  assign new_slot = '{pid: req_q.pid, key: req_q.burst_key, level: req_q.level,
                      bank: (req_q.func == FUNC_EXP) ? ~ab_q : ab_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (is_add && !full) begin
            state_d = (eff_mode == MODE_SJF && cnt_q != '0) ? ST_SCAN : ST_WRNEW;
          end else if (is_get && cnt_q != '0) begin
            state_d = (eff_mode == MODE_PRIO) ? ST_SCAN : ST_RDREQ;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (mode_q == MODE_SJF) begin
          if (sjf_hit) begin
            state_d = ST_SHDN;
          end else if (scan_last) begin
            state_d = ST_WRNEW;
          end
        end else if (scan_last) begin
          state_d = ST_SHUP;
        end
      end
      ST_RDREQ: state_d = ST_RDCAP;
      ST_RDCAP: state_d = ST_SHUP;
      ST_SHUP: begin
        if (shift_done) state_d = ST_DONE;
      end
      ST_SHDN: begin
        if (shift_done) state_d = ST_WRNEW;
      end
      ST_WRNEW: state_d = ST_DONE;
      ST_DONE: begin
        if (res_take_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    req_d    = req_q;
    mode_d   = mode_q;
    cnt_d    = cnt_q;
    ab_d     = ab_q;
    pos_d    = pos_q;
    idx_d    = idx_q;
    pidx_d   = pidx_q;
    act_d    = act_q;
    pend_d   = pend_q;
    pid_d    = pid_q;
    grant_d  = grant_q;
    status_d = status_q;
    bf_d     = bf_q;
    bl_d     = bl_q;
    bp_d     = bp_q;
    bpid_d   = bpid_q;
    sel      = ab_q;
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = new_slot;
    ram_re    = 1'b0;
    ram_raddr = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          req_d    = req_i;
          mode_d   = eff_mode;
          status_d = ST_OK;
          grant_d  = 1'b0;
          pid_d    = '0;
          idx_d    = '0;
          act_d    = (cnt_q != '0);
          pend_d   = 1'b0;
          bf_d     = '0;
          pos_d    = IdxW'(cnt_q);
          if (is_add && full) begin
            status_d = ST_FULL;
          end else if (is_get) begin
            if (cnt_q == '0) begin
              status_d = ST_EMPTY;
            end else if (eff_mode == MODE_LCFS) begin
              pos_d = cnt_last;
            end else begin
              pos_d = '0;
            end
          end
        end
      end
      ST_SCAN: begin
        // issue the next read
        if (act_q) begin
          ram_re = 1'b1;
          pend_d = 1'b1;
          pidx_d = idx_q;
          if (idx_q == cnt_last) begin
            act_d = 1'b0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else begin
          pend_d = 1'b0;
        end
        // look at the entry that came back
        if (mode_q == MODE_SJF) begin
          if (sjf_hit) begin
            pos_d  = pidx_q;
            idx_d  = cnt_last;
            act_d  = 1'b1;
            pend_d = 1'b0;
          end
        end else if (pend_q) begin
          if (!bf_q[rd.bank] || rd.level > bl_q[rd.bank]) begin
            bf_d[rd.bank]   = 1'b1;
            bl_d[rd.bank]   = rd.level;
            bp_d[rd.bank]   = pidx_q;
            bpid_d[rd.bank] = rd.pid;
          end
          if (scan_last) begin
            sel = bf_d[ab_q] ? ab_q : ~ab_q;
            ab_d    = sel;
            pos_d   = bp_d[sel];
            pid_d   = bpid_d[sel];
            grant_d = 1'b1;
            idx_d   = bp_d[sel] + 1'b1;
            act_d   = (CntW'(bp_d[sel]) + 1'b1 < cnt_q);
            pend_d  = 1'b0;
          end
        end
      end
      ST_RDREQ: begin
        ram_re    = 1'b1;
        ram_raddr = pos_q;
      end
      ST_RDCAP: begin
        pid_d   = rd.pid;
        grant_d = 1'b1;
        idx_d   = pos_q + 1'b1;
        act_d   = (CntW'(pos_q) + 1'b1 < cnt_q);
        pend_d  = 1'b0;
      end
      ST_SHUP: begin
        // close the gap: entry j moves to j-1
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pidx_q - 1'b1;
          ram_wdata = rd;
        end
        if (act_q) begin
          ram_re = 1'b1;
          pend_d = 1'b1;
          pidx_d = idx_q;
          if (idx_q == cnt_last) begin
            act_d = 1'b0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else begin
          pend_d = 1'b0;
        end
        if (shift_done) cnt_d = cnt_q - 1'b1;
      end
      ST_SHDN: begin
        // open a gap: entry j moves to j+1, from the top down
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pidx_q + 1'b1;
          ram_wdata = rd;
        end
        if (act_q) begin
          ram_re = 1'b1;
          pend_d = 1'b1;
          pidx_d = idx_q;
          if (idx_q == pos_q) begin
            act_d = 1'b0;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end else begin
          pend_d = 1'b0;
        end
      end
      ST_WRNEW: begin
        ram_we = 1'b1;
        cnt_d  = cnt_q + 1'b1;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ab_q    <= 1'b0;
      act_q   <= 1'b0;
      pend_q  <= 1'b0;
      bf_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ab_q    <= ab_d;
      act_q   <= act_d;
      pend_q  <= pend_d;
      bf_q    <= bf_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    mode_q   <= mode_d;
    pos_q    <= pos_d;
    idx_q    <= idx_d;
    pidx_q   <= pidx_d;
    pid_q    <= pid_d;
    grant_q  <= grant_d;
    status_q <= status_d;
    bl_q     <= bl_d;
    bp_q     <= bp_d;
    bpid_q   <= bpid_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o = '{pid_out: pid_q, grant_valid: grant_q, status: status_q,
                   queue_empty: (cnt_q == '0)};

endmodule

FILE: sv/ready_queue_scheduler.sv
// Ready-queue engine: one request in, one result transfer out. Entries sit in
// arrival order, shortest-job-first adds placed by key, in a slot memory with
// one write port and a registered read port (one read, one write per cycle),
// and every reorder walks that memory one entry per cycle. An add in fcfs,
// lcfs, round robin or priority mode writes the new entry at the end. A fifo
// or lcfs get removes the front or the newest entry and shifts the entries
// behind it down. A shortest-job-first add scans keys to the insert point,
// then shifts the entries from there up to open the slot. A priority get scans
// all count entries once to find the best entry of both banks, then closes the
// gap. One request is in flight at a time; the next is taken once the result
// has moved to the output register. policy_mode is written over the APB port
// at byte address 0.
module ready_queue_scheduler (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rqs_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rqs_pkg::rsp_t out_data_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [0:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import rqs_pkg::*;

  logic [2:0] mode_q, mode_d;
  logic       out_valid_q, out_valid_d;
  rsp_t       out_q;
  logic       busy, res_valid, res_take;
  rsp_t       res;
  logic       cfg_wr;

  // config register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_POLICY_MODE);
  assign mode_d = cfg_wr ? pwdata[2:0] : mode_q;
  assign prdata = (paddr == REG_POLICY_MODE) ? {29'd0, mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_FCFS;
    end else begin
      mode_q <= mode_d;
    end
  end

  rqs_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i && !busy),
    .req_i       (in_data_i),
    .mode_i      (mode_q),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res)
  );

  assign in_stall_o = busy;

  // output register
  assign res_take    = res_valid && (!out_valid_q || !out_stall_i);
  assign out_valid_d = res_take ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a grant always carries ok status
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.grant_valid |-> out_data_o.status == ST_OK)
    else $error("grant with error status");

  // an accepted request blocks the input until its result is out
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a request is in flight");

  // a dropped add means the store is full, hence not empty
  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_FULL |-> !out_data_o.queue_empty)
    else $error("full drop reported with empty store");

endmodule

FILE: tb/sv/testbench.sv
module testbench;
  import rqs_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  req_t        in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  rsp_t        out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [0:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ready_queue_scheduler DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor copy of the ready queue
  slot_t     q_slots[$];
  logic      q_active;
  logic [2:0] q_mode;
  rsp_t      grants_due[$];
  int        mismatches;
  bit        idle_on;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // oldest active-bank slot at the highest level, -1 if none
  function automatic int prio_pick();
    int best;
    int best_lvl;
    best = -1;
    best_lvl = -1;
    for (int i = 0; i < q_slots.size(); i++) begin
      if (q_slots[i].bank == q_active && int'(q_slots[i].level) > best_lvl) begin
        best_lvl = q_slots[i].level;
        best = i;
      end
    end
    return best;
  endfunction

  // compute the response for one request and update the queue copy
  function automatic rsp_t schedule_request(req_t r);
    rsp_t rs;
    logic [2:0] m;
    int pos;
    slot_t s;
    m = (q_mode > MODE_PRIO) ? MODE_FCFS : q_mode;
    rs = '0;
    if (r.func == FUNC_ADD || (r.func == FUNC_EXP && m == MODE_PRIO)) begin
      if (q_slots.size() >= QueueDepth) begin
        rs.status = ST_FULL;
      end else begin
        s.pid = r.pid;
        s.key = r.burst_key;
        s.level = r.level;
        s.bank = (r.func == FUNC_EXP) ? ~q_active : q_active;
        if (m == MODE_SJF) begin
          pos = q_slots.size();
          for (int i = 0; i < q_slots.size(); i++) begin
            if (r.burst_key < q_slots[i].key) begin
              pos = i;
              break;
            end
          end
          q_slots.insert(pos, s);
        end else begin
          q_slots.insert(q_slots.size(), s);
        end
      end
    end else if (r.func == FUNC_GET) begin
      if (q_slots.size() == 0) begin
        rs.status = ST_EMPTY;
      end else begin
        if (m == MODE_LCFS) begin
          pos = q_slots.size() - 1;
        end else if (m == MODE_PRIO) begin
          pos = prio_pick();
          if (pos < 0) begin
            q_active = ~q_active;
            pos = prio_pick();
          end
        end else begin
          pos = 0;
        end
        rs.pid_out = q_slots[pos].pid;
        rs.grant_valid = 1'b1;
        q_slots.delete(pos);
      end
    end
    rs.queue_empty = (q_slots.size() == 0);
    return rs;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // random sender gap
  task automatic maybe_pause();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  // one request transfer
  task automatic send_request(logic [1:0] f, logic [7:0] p, logic [15:0] k, logic [1:0] l);
    req_t r;
    r.func = f;
    r.pid = p;
    r.burst_key = k;
    r.level = l;
    maybe_pause();
    in_valid_i <= 1'b1;
    in_data_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    grants_due.insert(grants_due.size(), schedule_request(r));
    in_valid_i <= 1'b0;
    // the block stays busy for at least this cycle
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (grants_due.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // register write while idle
  task automatic set_mode(logic [2:0] m);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_POLICY_MODE;
    pwdata <= {29'd0, m};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    q_mode = m;
    @(posedge clk_i);
    if (prdata[2:0] !== m) report_mismatch("policy_mode readback", prdata[2:0], m);
  endtask

  task automatic random_request(int get_weight);
    logic [1:0] f;
    int dice;
    dice = $urandom_range(0, 99);
    if (dice < get_weight) f = FUNC_GET;
    else if (dice < 97) f = ($urandom_range(0, 3) == 0) ? FUNC_EXP : FUNC_ADD;
    else f = 2'd3;
    send_request(f, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                 2'($urandom_range(0, 3)));
  endtask

  task automatic test_directed();
    set_mode(MODE_FCFS);
    send_request(FUNC_GET, 8'd0, 16'd0, 2'd0);
    send_request(FUNC_ADD, 8'hFF, 16'hFFFF, 2'd3);
    send_request(FUNC_ADD, 8'h00, 16'h0000, 2'd0);
    send_request(FUNC_EXP, 8'h55, 16'h5555, 2'd1);
    send_request(2'd3, 8'hAA, 16'hAAAA, 2'd2);
    send_request(FUNC_GET, 8'd0, 16'd0, 2'd0);
    drain();
    set_mode(MODE_LCFS);
    send_request(FUNC_ADD, 8'h12, 16'd7, 2'd1);
    send_request(FUNC_GET, 8'd0, 16'd0, 2'd0);
    drain();
    set_mode(MODE_PRIO);
    send_request(FUNC_EXP, 8'h21, 16'd1, 2'd3);
    send_request(FUNC_ADD, 8'h22, 16'd2, 2'd0);
    send_request(FUNC_ADD, 8'h23, 16'd3, 2'd2);
    // active bank then swap to the expired one
    repeat (4) send_request(FUNC_GET, 8'd0, 16'd0, 2'd0);
    drain();
    set_mode(3'd7);
    send_request(FUNC_ADD, 8'h31, 16'd9, 2'd0);
    send_request(FUNC_EXP, 8'h32, 16'd9, 2'd0);
    send_request(FUNC_GET, 8'd0, 16'd0, 2'd0);
    send_request(FUNC_GET, 8'd0, 16'd0, 2'd0);
    drain();
  endtask

  // fill past full in shortest job first, then drain in another mode
  task automatic test_full_store();
    set_mode(MODE_SJF);
    repeat (QueueDepth + 3) send_request(FUNC_ADD, 8'($urandom_range(0, 255)),
                                         16'($urandom_range(0, 40)),
                                         2'($urandom_range(0, 3)));
    drain();
    set_mode(MODE_RR);
    repeat (QueueDepth + 1) send_request(FUNC_GET, 8'd0, 16'd0, 2'd0);
    drain();
  endtask

  // random phases across modes, queue kept across mode changes
  task automatic test_random_modes();
    logic [2:0] modes[7] = '{MODE_FCFS, MODE_LCFS, MODE_SJF, MODE_RR, MODE_PRIO,
                             3'd5, 3'd6};
    for (int ph = 0; ph < 18; ph++) begin
      set_mode((ph < 7) ? modes[ph] : modes[$urandom_range(0, 6)]);
      if (ph == 15) idle_on = 1'b0;
      repeat (100) random_request((ph % 3 == 0) ? 25 : ((ph % 3 == 1) ? 45 : 60));
      drain();
    end
  endtask

  // response checker
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (grants_due.size() == 0) begin
        report_mismatch("unexpected response pid_out", out_data_o.pid_out, 0);
      end else begin
        want = grants_due.pop_front();
        if (out_data_o.pid_out !== want.pid_out)
          report_mismatch("pid_out", out_data_o.pid_out, want.pid_out);
        if (out_data_o.grant_valid !== want.grant_valid)
          report_mismatch("grant_valid", out_data_o.grant_valid, want.grant_valid);
        if (out_data_o.status !== want.status)
          report_mismatch("status", out_data_o.status, want.status);
        if (out_data_o.queue_empty !== want.queue_empty)
          report_mismatch("queue_empty", out_data_o.queue_empty, want.queue_empty);
      end
    end
  end

  // receiver stall bursts
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    idle_on = 1'b1;
    q_active = 1'b0;
    q_mode = MODE_FCFS;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_store();
    test_random_modes();
    drain();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/rqs_pkg.sv
sv/rqs_ram.sv
sv/rqs_engine.sv
sv/ready_queue_scheduler.sv
tb/sv/testbench.sv
